/* src/channel_matrix_mixer_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the channel matrix mixer
// Clocked assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_MATRIX_MIXER_CORE_ASSERT_SVH
`define CHANNEL_MATRIX_MIXER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define CMM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The expression must never be true at a clock edge outside reset.
`define CMM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CMM_ASSERT(lbl, clk, rst_n, prop, msg)
`define CMM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

/* src/cmm_pkg.sv */
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared widths, codes and defaults of the channel matrix mixer.
// ----------------------------------------------------------------------------
package cmm_pkg;

  // Default sizes of the mixing matrix and the coefficient format.
  localparam int unsigned DEF_MAX_ROWS       = 16;
  localparam int unsigned DEF_MAX_COLS       = 16;
  localparam int unsigned DEF_COEF_FRAC_BITS = 14;

  // Fixed field widths.
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned ROW_FW    = 4;
  localparam int unsigned COL_FW    = 4;
  localparam int unsigned COEF_W    = 18;
  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned OUT_CH_W  = 4;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned COL_POS_W = 4;

  // Configuration port.
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Register index codes, decoded from the upper address bit.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Item opcodes.
  localparam logic OPC_COEF   = 1'b0;
  localparam logic OPC_SAMPLE = 1'b1;

  // Output saturation limits.
  localparam logic [SAMPLE_W-1:0] OUT_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] OUT_MIN = 24'h800000;

endpackage

/* src/cmm_in_if.sv */
// ----------------------------------------------------------------------------
// cmm_in_if
// Input channel: coefficient writes and input samples.
// ----------------------------------------------------------------------------
interface cmm_in_if
  import cmm_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [ROW_FW-1:0]          coef_row;
  logic [COL_FW-1:0]          coef_col;
  logic signed [COEF_W-1:0]   coef_value;
  logic signed [SAMPLE_W-1:0] sample_value;

  modport source (
    output valid, opcode, coef_row, coef_col, coef_value, sample_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, coef_row, coef_col, coef_value, sample_value,
    output ready
  );
endinterface

/* src/cmm_out_if.sv */
// ----------------------------------------------------------------------------
// cmm_out_if
// Output channel: one mixed sample per output row.
// ----------------------------------------------------------------------------
interface cmm_out_if
  import cmm_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [OUT_CH_W-1:0]        out_channel;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       last_of_frame;
  logic                       saturated;

  modport source (
    output valid, out_channel, out_sample, last_of_frame, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_channel, out_sample, last_of_frame, saturated,
    output ready
  );
endinterface

/* src/cmm_ram.sv */
// ----------------------------------------------------------------------------
// cmm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cmm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/channel_matrix_mixer_core.sv */
// ----------------------------------------------------------------------------
// channel_matrix_mixer_core: audio mixing matrix with one shared multiply-accumulate.
// A coefficient item writes the coefficient memory directly; a sample item walks the active rows,
// one output row per cycle through the shared multiplier and accumulator memory.
// A frame-closing sample then reads out every output row in turn, held by any output stall.
// After reset the coefficient memory is swept to zero before any item is accepted.
// ----------------------------------------------------------------------------
`include "channel_matrix_mixer_core_assert.svh"

module channel_matrix_mixer_core
  import cmm_pkg::*;
#(
  parameter int unsigned MAX_ROWS       = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS       = DEF_MAX_COLS,
  parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cmm_in_if.sink            in_i,
  cmm_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned RA_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CC_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int unsigned CA_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RCW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW    = $clog2(MAX_COLS + 1);
  localparam int unsigned RCMP   = (RCW > CFG_W) ? RCW : CFG_W;
  localparam int unsigned CCMP   = (CCW > CFG_W) ? CCW : CFG_W;
  localparam int unsigned PROD_W = COEF_W + SAMPLE_W;
  localparam int unsigned NPOS   = 2 ** COL_POS_W;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_MAC      = 3'd2;
  localparam logic [2:0] ST_DRAIN    = 3'd3;
  localparam logic [2:0] ST_OUT_RD   = 3'd4;
  localparam logic [2:0] ST_OUT_CALC = 3'd5;

  // Control state.
  logic [2:0]           state_q, state_d;
  logic [CA_W-1:0]      clr_cnt_q, clr_cnt_d;
  logic [CFG_W-1:0]     rows_cfg_q, cols_cfg_q;
  logic [COL_POS_W-1:0] col_pos_q, col_pos_d;
  logic [RA_W-1:0]      row_q, row_d;
  logic                 s1_vld_q, s1_vld_d, s2_vld_q;
  logic [MAX_ROWS-1:0]  acc_vld_q;
  logic                 out_valid_q;

  // Payload state.
  logic [CC_W-1:0]            col_q;
  logic [RCW-1:0]             rows_q;
  logic                       eof_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [RA_W-1:0]            s1_row_q, s2_row_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic [ACC_W-1:0]           acc_hold_q;
  logic [OUT_CH_W-1:0]        out_ch_q;
  logic [SAMPLE_W-1:0]        out_sample_q;
  logic                       out_last_q, out_sat_q;

  // Memory ports.
  logic              coef_we;
  logic [CA_W-1:0]   coef_waddr, coef_raddr;
  logic [COEF_W-1:0] coef_wdata, coef_rdata;
  logic              acc_we;
  logic [ACC_W-1:0]  acc_wdata, acc_rdata, acc_base;
  logic [RA_W-1:0]   acc_raddr;

  // Miscellaneous datapath and control.
  logic                     cfg_we;
  logic                     in_acc;
  logic                     last_row;
  logic                     out_load;
  logic                     frame_done;
  logic                     sample_load;
  logic [RCMP-1:0]          rows_x, rows_eff;
  logic [CCMP-1:0]          cols_x, cols_eff;
  logic                     eof_now;
  logic                     coef_in_range;
  logic [ACC_W-1:0]         prod_ext;
  logic signed [ACC_W-1:0]  acc_cur, acc_sh;
  logic                     sat_hi, sat_lo;
  logic [SAMPLE_W-1:0]      res_sample;
  logic [CC_W-1:0]          col_mod [NPOS];

  // Column position folded into the matrix width.
  for (genvar g = 0; g < NPOS; g++) begin : g_colmod
    assign col_mod[g] = CC_W'(g % MAX_COLS);
  end

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= CFG_W'(1);
      cols_cfg_q <= CFG_W'(1);
    end else if (cfg_we) begin
      if (paddr[APB_AW-1] == REG_COLS) begin
        cols_cfg_q <= pwdata[CFG_W-1:0];
      end else begin
        rows_cfg_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[APB_AW-1] == REG_COLS) ? APB_DW'(cols_cfg_q) : APB_DW'(rows_cfg_q);

  // Clamp the row and column counts to 1..MAX.
  always_comb begin
    rows_x = RCMP'(rows_cfg_q);
    cols_x = CCMP'(cols_cfg_q);
    if (rows_x == '0) begin
      rows_eff = RCMP'(1);
    end else if (rows_x > RCMP'(MAX_ROWS)) begin
      rows_eff = RCMP'(MAX_ROWS);
    end else begin
      rows_eff = rows_x;
    end
    if (cols_x == '0) begin
      cols_eff = CCMP'(1);
    end else if (cols_x > CCMP'(MAX_COLS)) begin
      cols_eff = CCMP'(MAX_COLS);
    end else begin
      cols_eff = cols_x;
    end
  end

  assign eof_now       = (CCMP'(col_pos_q) + CCMP'(1)) >= cols_eff;
  assign coef_in_range = (RCMP'(in_i.coef_row) < RCMP'(MAX_ROWS)) &&
                         (CCMP'(in_i.coef_col) < CCMP'(MAX_COLS));

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign last_row   = (RCW'(row_q) == rows_q - RCW'(1));
  assign out_load   = (state_q == ST_OUT_CALC) && (!out_valid_q || out_o.ready);
  assign frame_done = out_load && last_row;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    col_pos_d   = col_pos_q;
    row_d       = row_q;
    s1_vld_d    = 1'b0;
    sample_load = 1'b0;
    coef_we     = 1'b0;
    coef_waddr  = CA_W'(in_i.coef_row) * CA_W'(MAX_COLS) + CA_W'(in_i.coef_col);
    coef_wdata  = in_i.coef_value;
    case (state_q)
      ST_CLEAR: begin
        coef_we    = 1'b1;
        coef_waddr = clr_cnt_q;
        coef_wdata = '0;
        clr_cnt_d  = clr_cnt_q + CA_W'(1);
        if (clr_cnt_q == CA_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.opcode == OPC_COEF) begin
            coef_we = coef_in_range;
          end else begin
            sample_load = 1'b1;
            row_d       = '0;
            col_pos_d   = eof_now ? '0 : col_pos_q + COL_POS_W'(1);
            state_d     = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        s1_vld_d = 1'b1;
        if (last_row) begin
          row_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          row_d = row_q + RA_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = eof_q ? ST_OUT_RD : ST_IDLE;
        end
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_CALC;
      end
      ST_OUT_CALC: begin
        if (out_load) begin
          if (last_row) begin
            state_d = ST_IDLE;
          end else begin
            row_d   = row_q + RA_W'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      col_pos_q <= '0;
      row_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      col_pos_q <= col_pos_d;
      row_q     <= row_d;
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s1_vld_q;
    end
  end

  // Per-item operands latched at acceptance of a sample.
  always_ff @(posedge clk_i) begin
    if (sample_load) begin
      sample_q <= in_i.sample_value;
      col_q    <= col_mod[col_pos_q];
      rows_q   <= RCW'(rows_eff);
      eof_q    <= eof_now;
    end
  end

  // Coefficient memory.
  assign coef_raddr = CA_W'(row_q) * CA_W'(MAX_COLS) + CA_W'(col_q);

  cmm_ram #(
    .WIDTH (COEF_W),
    .DEPTH (DEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  // Accumulator memory; a row without its valid bit reads as zero.
  assign acc_raddr = row_q;

  cmm_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_ROWS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (s2_row_q),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // Shared multiply stage, then accumulate stage.
  always_ff @(posedge clk_i) begin
    s1_row_q   <= row_q;
    s2_row_q   <= s1_row_q;
    prod_q     <= $signed(coef_rdata) * sample_q;
    acc_hold_q <= acc_rdata;
  end

  assign prod_ext  = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_base  = acc_vld_q[s2_row_q] ? acc_hold_q : '0;
  assign acc_wdata = acc_base + prod_ext;
  assign acc_we    = s2_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
    end else if (frame_done) begin
      acc_vld_q <= '0;
    end else if (acc_we) begin
      acc_vld_q[s2_row_q] <= 1'b1;
    end
  end

  // Frame result: arithmetic shift and saturation to the sample width.
  always_comb begin
    if (acc_vld_q[row_q]) begin
      acc_cur = $signed(acc_rdata);
    end else begin
      acc_cur = '0;
    end
    acc_sh = acc_cur >>> COEF_FRAC_BITS;
    sat_hi = acc_sh > $signed({{(ACC_W - SAMPLE_W){1'b0}}, OUT_MAX});
    sat_lo = acc_sh < $signed({{(ACC_W - SAMPLE_W){1'b1}}, OUT_MIN});
    if (sat_hi) begin
      res_sample = OUT_MAX;
    end else if (sat_lo) begin
      res_sample = OUT_MIN;
    end else begin
      res_sample = acc_sh[SAMPLE_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q     <= OUT_CH_W'(row_q);
      out_sample_q <= res_sample;
      out_last_q   <= last_row;
      out_sat_q    <= sat_hi | sat_lo;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_channel   = out_ch_q;
  assign out_o.out_sample    = $signed(out_sample_q);
  assign out_o.last_of_frame = out_last_q;
  assign out_o.saturated     = out_sat_q;

  // Accumulators are written only while a sample walks the rows.
  `CMM_ASSERT(a_acc_we_in_mac, clk_i, rst_ni, acc_we |-> (state_q == ST_MAC || state_q == ST_DRAIN), "accumulator written outside the accumulate phase")
  // A finished frame leaves every accumulator empty and the column at zero.
  `CMM_ASSERT(a_frame_clear, clk_i, rst_ni, frame_done |=> (acc_vld_q == '0 && col_pos_q == '0), "accumulators not cleared after frame")
  // Outside the reset sweep a coefficient write comes only from an accepted item.
  `CMM_ASSERT(a_coef_we_src, clk_i, rst_ni, (coef_we && state_q != ST_CLEAR) |-> (in_acc && in_i.opcode == OPC_COEF), "stray coefficient write")
  // No result is loaded while the multiply pipeline still holds a row.
  `CMM_ASSERT_NEVER(a_load_drained, clk_i, rst_ni, out_load && (s1_vld_q || s2_vld_q), "result loaded before accumulation finished")

endmodule

/* bench/channel_matrix_mixer_core_test.sv */
// ----------------------------------------------------------------------------
// channel_matrix_mixer_core_test
// Self-checking bench for the channel matrix mixer. A short table of directed
// items runs at the reset settings first. Random phases follow, each under
// its own rows/cols setting written over the register port. Every accepted
// item goes through a bit-exact mixing model, and each result item leaving
// the block is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module channel_matrix_mixer_core_test
  import cmm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NROWS        = DEF_MAX_ROWS;
  localparam int unsigned NCOLS        = DEF_MAX_COLS;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          CYCLE_LIMIT  = 300000;

  // Register addresses: one 32-bit word per register.
  localparam logic [APB_AW-1:0] ADDR_ROWS = {REG_ROWS, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_COLS = {REG_COLS, 2'b00};

  // Saturation bounds at accumulator width.
  localparam logic signed [ACC_W-1:0] ACC_TOP    = 48'sd8388607;
  localparam logic signed [ACC_W-1:0] ACC_BOTTOM = -48'sd8388608;

  typedef enum logic [1:0] {
    PH_MIX,
    PH_SAMPLES,
    PH_PRESSURE
  } phase_kind_e;

  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    logic [7:0]       n_items;
    phase_kind_e      kind;
  } phase_t;

  typedef struct {
    logic                       opcode;
    logic [ROW_FW-1:0]          coef_row;
    logic [COL_FW-1:0]          coef_col;
    logic signed [COEF_W-1:0]   coef_value;
    logic signed [SAMPLE_W-1:0] sample_value;
  } mix_item_t;

  typedef struct {
    logic [OUT_CH_W-1:0]        channel;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
    logic                       clipped;
  } mix_res_t;

  // One directed row; a typed-in result replaces the model's for that row.
  typedef struct {
    mix_item_t                  item;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] want_value;
    logic                       want_clip;
  } table_row_t;

  // Settings walked after the directed part; includes zero and oversize values.
  localparam phase_t PHASES [10] = '{
    '{5'd16, 5'd16, 8'd16, PH_MIX},
    '{5'd0,  5'd0,  8'd8,  PH_MIX},
    '{5'd31, 5'd31, 8'd16, PH_MIX},
    '{5'd16, 5'd16, 8'd8,  PH_SAMPLES},
    '{5'd4,  5'd3,  8'd10, PH_MIX},
    '{5'd16, 5'd1,  8'd20, PH_PRESSURE},
    '{5'd17, 5'd5,  8'd14, PH_MIX},
    '{5'd2,  5'd20, 8'd16, PH_MIX},
    '{5'd8,  5'd4,  8'd14, PH_MIX},
    '{5'd1,  5'd2,  8'd12, PH_MIX}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  cmm_in_if  in_bus ();
  cmm_out_if out_bus ();

  channel_matrix_mixer_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mixing model state.
  logic signed [COEF_W-1:0] coef_mem [NROWS][NCOLS];
  logic signed [ACC_W-1:0]  row_acc [NROWS];
  logic [COL_POS_W-1:0]     col_pos;
  logic [CFG_W-1:0]         rows_reg;
  logic [CFG_W-1:0]         cols_reg;
  mix_res_t                 frame_res [NROWS];
  mix_res_t                 pending_mix [$];

  int  cycle_cnt;
  int  err_cnt;
  int  n_items;
  int  n_samples;
  int  n_coefs;
  int  n_results;
  int  n_clipped;
  int  n_settings;
  int  burst_left;
  bit  offering;
  bit  hold_req;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle count and run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_cnt, pending_mix.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Effective row or column count: zero acts as one, oversize as the maximum.
  function automatic int eff_count(logic [CFG_W-1:0] v, int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // Applies one item to the model; returns how many results it closes out.
  function automatic int mix_item(mix_item_t it);
    int                      nr;
    int                      nc;
    logic signed [ACC_W-1:0] c48;
    logic signed [ACC_W-1:0] s48;
    logic signed [ACC_W-1:0] scaled;
    nr = eff_count(rows_reg, NROWS);
    nc = eff_count(cols_reg, NCOLS);
    if (it.opcode == OPC_COEF) begin
      coef_mem[it.coef_row][it.coef_col] = it.coef_value;
      return 0;
    end
    s48 = it.sample_value;
    for (int r = 0; r < nr; r++) begin
      c48 = coef_mem[r][col_pos];
      row_acc[r] = row_acc[r] + c48 * s48;
    end
    // The frame continues unless this was its last active column, or the
    // column count has shrunk below the current position.
    if (int'(col_pos) + 1 < nc) begin
      col_pos = col_pos + 1'b1;
      return 0;
    end
    for (int r = 0; r < nr; r++) begin
      scaled = row_acc[r] >>> DEF_COEF_FRAC_BITS;
      frame_res[r].channel = OUT_CH_W'(r);
      frame_res[r].last    = (r == nr - 1);
      if (scaled > ACC_TOP) begin
        frame_res[r].value   = OUT_MAX;
        frame_res[r].clipped = 1'b1;
      end else if (scaled < ACC_BOTTOM) begin
        frame_res[r].value   = OUT_MIN;
        frame_res[r].clipped = 1'b1;
      end else begin
        frame_res[r].value   = scaled[SAMPLE_W-1:0];
        frame_res[r].clipped = 1'b0;
      end
    end
    for (int r = 0; r < NROWS; r++) row_acc[r] = '0;
    col_pos = '0;
    return nr;
  endfunction

  // Books an accepted item: updates the model and queues its results.
  task automatic book_item(table_row_t row);
    int       n;
    mix_res_t want;
    n = mix_item(row.item);
    n_items++;
    if (row.item.opcode == OPC_COEF) n_coefs++;
    else n_samples++;
    if (row.typed) begin
      want.channel = '0;
      want.value   = row.want_value;
      want.last    = 1'b1;
      want.clipped = row.want_clip;
      pending_mix.push_back(want);
    end else begin
      for (int r = 0; r < n; r++) pending_mix.push_back(frame_res[r]);
    end
  endtask

  // Directed rows: a coefficient write, or a sample with an optional result.
  function automatic table_row_t coef_w(int r, int c, int v);
    table_row_t row;
    row.item.opcode       = OPC_COEF;
    row.item.coef_row     = ROW_FW'(r);
    row.item.coef_col     = COL_FW'(c);
    row.item.coef_value   = COEF_W'(v);
    row.item.sample_value = SAMPLE_W'($urandom);
    row.typed             = 1'b0;
    row.want_value        = '0;
    row.want_clip         = 1'b0;
    return row;
  endfunction

  function automatic table_row_t samp(int s, bit typed = 1'b0, int want = 0,
                                      bit clip = 1'b0);
    table_row_t row;
    row.item.opcode       = OPC_SAMPLE;
    row.item.coef_row     = ROW_FW'($urandom);
    row.item.coef_col     = COL_FW'($urandom);
    row.item.coef_value   = COEF_W'($urandom);
    row.item.sample_value = SAMPLE_W'(s);
    row.typed             = typed;
    row.want_value        = SAMPLE_W'(want);
    row.want_clip         = clip;
    return row;
  endfunction

  // Random item; coefficient writes aim at the active part half the time.
  function automatic mix_item_t rand_item(bit samples_only);
    mix_item_t it;
    int        nr;
    int        nc;
    nr = eff_count(rows_reg, NROWS);
    nc = eff_count(cols_reg, NCOLS);
    it.opcode   = (samples_only || $urandom_range(0, 9) >= 3) ? OPC_SAMPLE : OPC_COEF;
    it.coef_row = ROW_FW'($urandom);
    it.coef_col = COL_FW'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      it.coef_row = ROW_FW'($urandom_range(0, nr - 1));
      it.coef_col = COL_FW'($urandom_range(0, nc - 1));
    end
    case ($urandom_range(0, 3))
      0: it.coef_value = COEF_W'($urandom);
      1: it.coef_value = COEF_W'(int'($urandom_range(0, 4095)) - 2048);
      2: it.coef_value = COEF_W'(16384 + int'($urandom_range(0, 511)) - 256);
      default: it.coef_value = ($urandom_range(0, 1) == 0) ? COEF_W'(131071)
                                                         : COEF_W'(-131072);
    endcase
    case ($urandom_range(0, 5))
      0: it.sample_value = ($urandom_range(0, 1) == 0) ? SAMPLE_W'(8388607)
                                                     : SAMPLE_W'(-8388608);
      1: it.sample_value = SAMPLE_W'(int'($urandom_range(0, 65535)) - 32768);
      default: it.sample_value = SAMPLE_W'($urandom);
    endcase
    return it;
  endfunction

  // Offers one item and waits for the edge that accepts it. Bursts end in
  // a random gap with valid low.
  task automatic send(mix_item_t it);
    in_bus.valid        <= 1'b1;
    in_bus.opcode       <= it.opcode;
    in_bus.coef_row     <= it.coef_row;
    in_bus.coef_col     <= it.coef_col;
    in_bus.coef_value   <= it.coef_value;
    in_bus.sample_value <= it.sample_value;
    offering = 1'b1;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      in_bus.valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
  endtask

  // Waits until the block has delivered everything and gone quiet.
  task automatic wait_idle();
    if (offering) begin
      in_bus.valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_mix.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write: setup phase, access phase until pready, then the bus
  // returns to idle.
  task automatic reg_write(logic [APB_AW-1:0] addr, logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {(APB_DW - CFG_W)'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_ROWS) rows_reg = val;
    else cols_reg = val;
    @(posedge clk_i);
  endtask

  task automatic flag_mismatch(string msg);
    $display("Mismatch at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    mix_res_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_mix.size() == 0) begin
        flag_mismatch($sformatf("unexpected result, channel %0d sample %0d",
                                out_bus.out_channel, out_bus.out_sample));
      end else begin
        want = pending_mix.pop_front();
        n_results++;
        if (want.clipped) n_clipped++;
        if (out_bus.out_channel !== want.channel)
          flag_mismatch($sformatf("out_channel %0d, expected %0d",
                                  out_bus.out_channel, want.channel));
        if (out_bus.out_sample !== want.value)
          flag_mismatch($sformatf("channel %0d out_sample %0d, expected %0d",
                                  want.channel, out_bus.out_sample, want.value));
        if (out_bus.last_of_frame !== want.last)
          flag_mismatch($sformatf("channel %0d last_of_frame %b, expected %b",
                                  want.channel, out_bus.last_of_frame, want.last));
        if (out_bus.saturated !== want.clipped)
          flag_mismatch($sformatf("channel %0d saturated %b, expected %b",
                                  want.channel, out_bus.saturated, want.clipped));
      end
    end
  end

  // Receiver: ready pattern switches among random modes; one long
  // hold-off on request lets the block back up into its input.
  initial begin
    int rx_mode;
    int rx_left;
    rx_mode = 0;
    rx_left = 0;
    out_bus.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        if (rx_left <= 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(20, 80);
        end
        rx_left--;
        case (rx_mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= cycle_cnt[0];
          2: out_bus.ready <= 1'($urandom_range(0, 1));
          default: out_bus.ready <= ($urandom_range(0, 6) != 0);
        endcase
      end
    end
  end

  // Main sequence.
  initial begin
    table_row_t dir_tab [$];
    table_row_t row;
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.opcode       <= OPC_COEF;
    in_bus.coef_row     <= '0;
    in_bus.coef_col     <= '0;
    in_bus.coef_value   <= '0;
    in_bus.sample_value <= '0;
    cycle_cnt  = 0;
    err_cnt    = 0;
    n_items    = 0;
    n_samples  = 0;
    n_coefs    = 0;
    n_results  = 0;
    n_clipped  = 0;
    n_settings = 1;
    burst_left = 4;
    offering   = 1'b0;
    hold_req   = 1'b0;
    rows_reg   = 5'd1;
    cols_reg   = 5'd1;
    col_pos    = '0;
    for (int r = 0; r < NROWS; r++) begin
      row_acc[r] = '0;
      for (int c = 0; c < NCOLS; c++) coef_mem[r][c] = '0;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset setting: one row, one column per frame.
    dir_tab.push_back(samp(8388607, 1, 0, 0));        // store is clear after reset
    dir_tab.push_back(samp(-8388608, 1, 0, 0));
    dir_tab.push_back(coef_w(15, 15, -131072));      // far corner, not in use
    dir_tab.push_back(coef_w(0, 15, 131071));        // inactive column
    dir_tab.push_back(coef_w(0, 0, 131071));
    dir_tab.push_back(samp(8388607, 1, 8388607, 1));
    dir_tab.push_back(samp(-8388608, 1, -8388608, 1));
    dir_tab.push_back(samp(0, 1, 0, 0));
    dir_tab.push_back(coef_w(0, 0, -131072));
    dir_tab.push_back(samp(8388607, 1, -8388608, 1));
    dir_tab.push_back(samp(-8388608, 1, 8388607, 1));
    dir_tab.push_back(samp(1, 1, -8, 0));
    dir_tab.push_back(coef_w(0, 0, 16384));          // unity gain
    dir_tab.push_back(samp(8388607, 1, 8388607, 0));
    dir_tab.push_back(samp(-8388608, 1, -8388608, 0));
    dir_tab.push_back(samp(-1, 1, -1, 0));
    dir_tab.push_back(coef_w(0, 0, 1));              // smallest step: floor rounding
    dir_tab.push_back(samp(-1, 1, -1, 0));
    dir_tab.push_back(samp(1, 1, 0, 0));
    dir_tab.push_back(samp(16383, 1, 0, 0));
    dir_tab.push_back(samp(16384, 1, 1, 0));
    dir_tab.push_back(coef_w(0, 0, 12345));
    dir_tab.push_back(samp(777777));
    dir_tab.push_back(samp(-4242424));
    dir_tab.push_back(coef_w(0, 0, 0));
    dir_tab.push_back(samp(5, 1, 0, 0));

    foreach (dir_tab[i]) begin
      send(dir_tab[i].item);
      book_item(dir_tab[i]);
    end

    // Random phases. A frame left open by one phase carries into the next,
    // so a smaller column count can close it early.
    foreach (PHASES[p]) begin
      wait_idle();
      reg_write(ADDR_ROWS, PHASES[p].rows);
      reg_write(ADDR_COLS, PHASES[p].cols);
      n_settings++;
      if (PHASES[p].kind == PH_PRESSURE) hold_req = 1'b1;
      for (int k = 0; k < int'(PHASES[p].n_items); k++) begin
        row.item  = rand_item(PHASES[p].kind != PH_MIX);
        row.typed = 1'b0;
        send(row.item);
        book_item(row);
      end
    end

    wait_idle();

    $display("Ran %0d items (%0d samples, %0d coefficient writes) over %0d settings.",
             n_items, n_samples, n_coefs, n_settings);
    $display("Checked %0d results, %0d of them clipped; %0d mismatches.",
             n_results, n_clipped, err_cnt);
    if (err_cnt == 0 && pending_mix.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
